@@ hw/rtl/ssco_pkg.sv @@
// shared constants for the swept sphere / capsule overlap core
// no dependencies
package ssco_pkg;

  localparam int unsigned COORD_BITS_DEF = 21;  // bits of one packed coordinate
  localparam int unsigned RADIUS_BITS    = 20;  // bits of each radius field
  localparam int unsigned WORD_BITS      = 63;  // bits of one packed position word
  localparam int unsigned LIMB_BITS      = 32;  // operand slice of one multiplier cell
  localparam int unsigned NUM_STAGES     = 11;  // register stages from input to result

endpackage

@@ hw/rtl/swept_sphere_capsule_overlap_test_core.sv @@
// A new word can enter each cycle unless a stalled result holds the pipeline. The pipeline
// is built from three rounds of limb-sliced multipliers (projection rejection, axis lengths
// and dot products, then squares against the radius term), each two stages deep, plus the
// difference, product, sum and compare stages around them. A stalled result freezes the
// whole pipeline; nothing is dropped or repeated.
//
// top level of the swept sphere / capsule overlap core
// depends on ssco_pkg and ssco_mul
module swept_sphere_capsule_overlap_test_core #(
  parameter int unsigned COORD_BITS = ssco_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ssco_pkg::WORD_BITS-1:0]   sphere_start_i,
  input  logic [ssco_pkg::WORD_BITS-1:0]   sphere_end_i,
  input  logic [ssco_pkg::WORD_BITS-1:0]   axis_start_before_i,
  input  logic [ssco_pkg::WORD_BITS-1:0]   axis_end_before_i,
  input  logic [ssco_pkg::WORD_BITS-1:0]   axis_start_after_i,
  input  logic [ssco_pkg::WORD_BITS-1:0]   axis_end_after_i,
  input  logic [ssco_pkg::RADIUS_BITS-1:0] ball_radius_i,
  input  logic [ssco_pkg::RADIUS_BITS-1:0] tube_radius_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             colliding_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned R    = ssco_pkg::RADIUS_BITS;
  localparam int unsigned NST  = ssco_pkg::NUM_STAGES;
  localparam int unsigned D1   = C + 1;          // point offsets, cylinder axis
  localparam int unsigned M    = C + 2;          // relative motion
  localparam int unsigned MMW  = 2 * M + 1;      // motion dot products
  localparam int unsigned NW   = 3 * C + 6;      // axis components
  localparam int unsigned EW   = 4 * C + 8;      // projections onto an axis
  localparam int unsigned NNW  = 2 * NW + 1;     // squared axis length
  localparam int unsigned RRW  = 2 * (R + 1) + 1;// squared radius sum, signed container
  localparam int unsigned EEW  = 2 * EW;
  localparam int unsigned RNW  = RRW + NNW;
  localparam int unsigned CMPW = (EEW > RNW) ? EEW : RNW;

  logic en;
  logic [NST-1:0] valid_q;

  assign en          = !valid_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: unpack and form offsets and motions
  logic signed [C-1:0]  sp0 [3];
  logic signed [C-1:0]  sp1 [3];
  logic signed [C-1:0]  cs0 [3];
  logic signed [C-1:0]  ce0 [3];
  logic signed [C-1:0]  cs1 [3];
  logic signed [C-1:0]  ce1 [3];
  logic signed [D1-1:0] pt_d [4][3];
  logic signed [D1-1:0] ax_d [3];
  logic signed [M-1:0]  mv_d [2][3];
  logic [R:0]           rsum_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sp0[k] = sphere_start_i[k*C +: C];
      sp1[k] = sphere_end_i[k*C +: C];
      cs0[k] = axis_start_before_i[k*C +: C];
      ce0[k] = axis_end_before_i[k*C +: C];
      cs1[k] = axis_start_after_i[k*C +: C];
      ce1[k] = axis_end_after_i[k*C +: C];
    end
    for (int k = 0; k < 3; k++) begin
      pt_d[0][k] = cs0[k] - sp0[k];
      pt_d[1][k] = ce0[k] - sp0[k];
      pt_d[2][k] = cs1[k] - sp1[k];
      pt_d[3][k] = ce1[k] - sp1[k];
      ax_d[k]    = ce0[k] - cs0[k];
      // motion of the sphere relative to each cylinder end
      mv_d[0][k] = sp1[k] - sp0[k] + cs0[k] - cs1[k];
      mv_d[1][k] = sp1[k] - sp0[k] + ce0[k] - ce1[k];
    end
    rsum_d = (R+1)'(ball_radius_i) + (R+1)'(tube_radius_i);
  end

  logic signed [D1-1:0]  pt_q [1:5][4][3];
  logic signed [D1-1:0]  ax_q [3];
  logic signed [M-1:0]   mv_q [1:2][2][3];
  logic [R:0]            rsum_q;

  // stage 2 products
  logic signed [MMW-1:0]   mm_q [2];
  logic signed [MMW-1:0]   am_q [2];
  logic signed [D1+M-1:0]  crp_q [6];
  logic signed [RRW-1:0]   rr_q [2:8];
  logic signed [NW-1:0]    cr_q [3:4][3];
  logic                    mmz_q [3:4][2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q[1]   <= pt_d;
      ax_q      <= ax_d;
      mv_q[1]   <= mv_d;
      rsum_q    <= rsum_d;
      for (int s = 2; s <= 5; s++) pt_q[s] <= pt_q[s-1];
      mv_q[2]   <= mv_q[1];
      for (int v = 0; v < 2; v++) begin
        mm_q[v] <= mv_q[1][v][0] * mv_q[1][v][0] + mv_q[1][v][1] * mv_q[1][v][1]
                 + mv_q[1][v][2] * mv_q[1][v][2];
        am_q[v] <= pt_q[1][v][0] * mv_q[1][v][0] + pt_q[1][v][1] * mv_q[1][v][1]
                 + pt_q[1][v][2] * mv_q[1][v][2];
      end
      // cross product of the start point motion with the cylinder axis
      crp_q[0]  <= mv_q[1][0][1] * ax_q[2];
      crp_q[1]  <= mv_q[1][0][2] * ax_q[1];
      crp_q[2]  <= mv_q[1][0][2] * ax_q[0];
      crp_q[3]  <= mv_q[1][0][0] * ax_q[2];
      crp_q[4]  <= mv_q[1][0][0] * ax_q[1];
      crp_q[5]  <= mv_q[1][0][1] * ax_q[0];
      rr_q[2]   <= rsum_q * rsum_q;
      for (int s = 3; s <= 8; s++) rr_q[s] <= rr_q[s-1];
      for (int i = 0; i < 3; i++) cr_q[3][i] <= crp_q[2*i] - crp_q[2*i+1];
      cr_q[4]   <= cr_q[3];
      for (int v = 0; v < 2; v++) mmz_q[3][v] <= (mm_q[v] == '0);
      mmz_q[4]  <= mmz_q[3];
    end
  end

  // stages 3-4: rejection products mm*a and (a.m)*m
  logic signed [MMW+D1-1:0] pr_p [2][3];
  logic signed [MMW+M-1:0]  pr_q [2][3];

  for (genvar v = 0; v < 2; v++) begin : g_rej
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      ssco_mul #(.AW(MMW), .BW(D1)) u_mul_p (
        .clk_i(clk_i), .en_i(en), .a_i(mm_q[v]), .b_i(pt_q[2][v][i]), .p_o(pr_p[v][i])
      );
      ssco_mul #(.AW(MMW), .BW(M)) u_mul_q (
        .clk_i(clk_i), .en_i(en), .a_i(am_q[v]), .b_i(mv_q[2][v][i]), .p_o(pr_q[v][i])
      );
    end
  end

  // stage 5: the three axes (the fourth is the negated cross product)
  logic signed [NW-1:0] n_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          // no relative motion: the axis is the plain offset
          if (mmz_q[4][v]) n_q[v][i] <= pt_q[4][v][i];
          else             n_q[v][i] <= NW'(pr_p[v][i] - pr_q[v][i]);
        end
      end
      n_q[2] <= cr_q[4];
    end
  end

  // stages 6-7: axis squares and point projections
  logic signed [2*NW-1:0]   sq_p [3][3];
  logic signed [D1+NW-1:0]  ep_p [3][4][3];

  for (genvar k = 0; k < 3; k++) begin : g_ax
    for (genvar i = 0; i < 3; i++) begin : g_sq
      ssco_mul #(.AW(NW), .BW(NW)) u_mul_sq (
        .clk_i(clk_i), .en_i(en), .a_i(n_q[k][i]), .b_i(n_q[k][i]), .p_o(sq_p[k][i])
      );
    end
    for (genvar p = 0; p < 4; p++) begin : g_pt
      for (genvar i = 0; i < 3; i++) begin : g_ep
        ssco_mul #(.AW(D1), .BW(NW)) u_mul_ep (
          .clk_i(clk_i), .en_i(en), .a_i(pt_q[5][p][i]), .b_i(n_q[k][i]),
          .p_o(ep_p[k][p][i])
        );
      end
    end
  end

  // stage 8: sums
  logic signed [NNW-1:0] nn_q [3];
  logic signed [EW-1:0]  e_q [3][4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nn_q[k] <= sq_p[k][0] + sq_p[k][1] + sq_p[k][2];
        for (int p = 0; p < 4; p++) begin
          e_q[k][p] <= ep_p[k][p][0] + ep_p[k][p][1] + ep_p[k][p][2];
        end
      end
    end
  end

  // stages 9-10: squared projections against radius^2 * |n|^2
  logic signed [RNW-1:0] rn_p [3];
  logic signed [EEW-1:0] ee_p [3][4];

  for (genvar k = 0; k < 3; k++) begin : g_fin
    ssco_mul #(.AW(RRW), .BW(NNW)) u_mul_rn (
      .clk_i(clk_i), .en_i(en), .a_i(rr_q[8]), .b_i(nn_q[k]), .p_o(rn_p[k])
    );
    for (genvar p = 0; p < 4; p++) begin : g_ee
      ssco_mul #(.AW(EW), .BW(EW)) u_mul_ee (
        .clk_i(clk_i), .en_i(en), .a_i(e_q[k][p]), .b_i(e_q[k][p]), .p_o(ee_p[k][p])
      );
    end
  end

  logic pos_q [9:10][3][4];
  logic neg_q [9:10][3][4];
  logic nnz_q [9:10][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nnz_q[9][k] <= (nn_q[k] == '0);
        for (int p = 0; p < 4; p++) begin
          neg_q[9][k][p] <= e_q[k][p][EW-1];
          pos_q[9][k][p] <= !e_q[k][p][EW-1] && (e_q[k][p] != '0);
        end
      end
      pos_q[10] <= pos_q[9];
      neg_q[10] <= neg_q[9];
      nnz_q[10] <= nnz_q[9];
    end
  end

  // stage 11: separation decision
  logic [CMPW-1:0] ee_x;
  logic [CMPW-1:0] rn_x;
  logic            far [3][4];
  logic            sep_any;
  logic            colliding_q;

  always_comb begin
    sep_any = 1'b0;
    ee_x    = '0;
    rn_x    = '0;
    for (int k = 0; k < 3; k++) begin
      for (int p = 0; p < 4; p++) begin
        ee_x       = CMPW'($unsigned(ee_p[k][p]));
        rn_x       = CMPW'($unsigned(rn_p[k]));
        far[k][p]  = ee_x > rn_x;
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (!nnz_q[10][k] && pos_q[10][k][0] && far[k][0] && pos_q[10][k][1] && far[k][1]
          && pos_q[10][k][2] && far[k][2] && pos_q[10][k][3] && far[k][3]) begin
        sep_any = 1'b1;
      end
    end
    // cross product axis in both directions
    if (!nnz_q[10][2] && far[2][0] && far[2][1] && far[2][2] && far[2][3]) begin
      if ((pos_q[10][2][0] && pos_q[10][2][1] && pos_q[10][2][2] && pos_q[10][2][3]) ||
          (neg_q[10][2][0] && neg_q[10][2][1] && neg_q[10][2][2] && neg_q[10][2][3])) begin
        sep_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      colliding_q <= !sep_any;
    end
  end

  assign colliding_o = colliding_q;

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("pipeline valid bits moved during a stall");

  a_entry_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> valid_q[0] == $past(in_valid_i))
    else $error("first stage valid does not follow the input handshake");

  a_word_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && valid_q[NST-2] |=> out_valid_o)
    else $error("word lost before the output register");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !valid_q[NST-2] |=> !out_valid_o)
    else $error("result word appeared without a word behind it");

endmodule

@@ hw/rtl/ssco_mul.sv @@
// two-stage signed multiplier built from limb-sized partial products
// depends on ssco_pkg
module ssco_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned LB = ssco_pkg::LIMB_BITS;
  localparam int unsigned NA = (AW + LB - 1) / LB;
  localparam int unsigned NB = (BW + LB - 1) / LB;
  localparam int unsigned SW = (NA + NB) * LB;
  localparam int unsigned PW = AW + BW;

  logic signed [NA*LB-1:0] a_ext;
  logic signed [NB*LB-1:0] b_ext;
  logic signed [LB:0]      a_ch [NA];
  logic signed [LB:0]      b_ch [NB];
  logic signed [2*LB+1:0]  pp_q [NA][NB];
  logic signed [SW-1:0]    acc;
  logic signed [PW-1:0]    p_q;

  assign a_ext = a_i;
  assign b_ext = b_i;

  // only the top limb carries the sign, lower limbs are unsigned
  for (genvar i = 0; i < NA; i++) begin : g_ach
    assign a_ch[i] = {((i == NA - 1) ? a_ext[NA*LB-1] : 1'b0), a_ext[i*LB +: LB]};
  end
  for (genvar j = 0; j < NB; j++) begin : g_bch
    assign b_ch[j] = {((j == NB - 1) ? b_ext[NB*LB-1] : 1'b0), b_ext[j*LB +: LB]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_ch[i] * b_ch[j];
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] t;
    acc = '0;
    t   = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        t   = pp_q[i][j];
        acc = acc + (t <<< (LB * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[PW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for swept_sphere_capsule_overlap_test_core: directed and random queries
// checked against an exact integer predictor; depends on ssco_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CB = ssco_pkg::COORD_BITS_DEF;
  localparam int unsigned WB = ssco_pkg::WORD_BITS;
  localparam int unsigned RB = ssco_pkg::RADIUS_BITS;

  typedef logic signed [255:0] big_t;
  typedef longint vec3_t [3];

  typedef struct {
    logic [WB-1:0] pos [6];  // sphere start/end, axis start/end before, after
    logic [RB-1:0] ball;
    logic [RB-1:0] tube;
  } query_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WB-1:0] pos_w [6];
  logic [RB-1:0] ball_w = '0;
  logic [RB-1:0] tube_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic colliding;

  bit expected_hits [$];
  int mismatches = 0;
  bit failed = 1'b0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  initial for (int i = 0; i < 6; i++) pos_w[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  swept_sphere_capsule_overlap_test_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .sphere_start_i(pos_w[0]), .sphere_end_i(pos_w[1]),
    .axis_start_before_i(pos_w[2]), .axis_end_before_i(pos_w[3]),
    .axis_start_after_i(pos_w[4]), .axis_end_after_i(pos_w[5]),
    .ball_radius_i(ball_w), .tube_radius_i(tube_w),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .colliding_o(colliding)
  );

  // ---------------- predictor ----------------
  function automatic vec3_t unpack_pos(input logic [WB-1:0] w);
    vec3_t v;
    for (int k = 0; k < 3; k++) v[k] = longint'(signed'(w[k*CB +: CB]));
    return v;
  endfunction

  function automatic logic [WB-1:0] pack_pos(input longint x, y, z);
    logic [CB-1:0] fx, fy, fz;
    fx = x[CB-1:0];
    fy = y[CB-1:0];
    fz = z[CB-1:0];
    return {fz, fy, fx};
  endfunction

  // offset with its motion component removed, scaled by |m|^2
  function automatic void rejected_axis(input vec3_t a, input vec3_t m, output big_t n [3]);
    longint mm, am;
    mm = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    am = a[0]*m[0] + a[1]*m[1] + a[2]*m[2];
    for (int i = 0; i < 3; i++)
      n[i] = (mm == 0) ? big_t'(a[i]) : big_t'(mm)*big_t'(a[i]) - big_t'(am)*big_t'(m[i]);
  endfunction

  function automatic bit point_clear(input vec3_t p, input vec3_t s, input big_t n [3],
                                     input big_t rr_nn);
    big_t e;
    e = 0;
    for (int i = 0; i < 3; i++) e += big_t'(p[i] - s[i]) * n[i];
    if (e <= 0) return 1'b0;
    return (e * e) > rr_nn;
  endfunction

  function automatic bit predict_colliding(input query_t q);
    vec3_t sp0, sp1, cs0, ce0, cs1, ce1, a, b, ma, mb, rel, ax, cr;
    big_t axes [4][3];
    big_t n [3];
    big_t rr, nn;
    longint rsum;
    sp0 = unpack_pos(q.pos[0]);
    sp1 = unpack_pos(q.pos[1]);
    cs0 = unpack_pos(q.pos[2]);
    ce0 = unpack_pos(q.pos[3]);
    cs1 = unpack_pos(q.pos[4]);
    ce1 = unpack_pos(q.pos[5]);
    rsum = longint'(q.ball) + longint'(q.tube);
    rr = big_t'(rsum * rsum);
    for (int i = 0; i < 3; i++) begin
      a[i] = cs0[i] - sp0[i];
      b[i] = ce0[i] - sp0[i];
      ma[i] = sp1[i] - sp0[i] + cs0[i] - cs1[i];
      mb[i] = sp1[i] - sp0[i] + ce0[i] - ce1[i];
      rel[i] = (sp1[i] - sp0[i]) - (cs1[i] - cs0[i]);
      ax[i] = ce0[i] - cs0[i];
    end
    cr[0] = rel[1]*ax[2] - rel[2]*ax[1];
    cr[1] = rel[2]*ax[0] - rel[0]*ax[2];
    cr[2] = rel[0]*ax[1] - rel[1]*ax[0];
    rejected_axis(a, ma, n);
    axes[0] = n;
    rejected_axis(b, mb, n);
    axes[1] = n;
    for (int i = 0; i < 3; i++) begin
      axes[2][i] = big_t'(cr[i]);
      axes[3][i] = -big_t'(cr[i]);
    end
    for (int k = 0; k < 4; k++) begin
      n = axes[k];
      nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
      if (nn != 0 && point_clear(cs0, sp0, n, rr*nn) && point_clear(ce0, sp0, n, rr*nn) &&
          point_clear(cs1, sp1, n, rr*nn) && point_clear(ce1, sp1, n, rr*nn))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------- driving ----------------
  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(6, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_word(input query_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 6; i++) pos_w[i] <= q.pos[i];
    ball_w <= q.ball;
    tube_w <= q.tube;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hits.push_back(predict_colliding(q));
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: colliding=%0b", colliding);
      end else begin
        bit exp_hit;
        exp_hit = expected_hits.pop_front();
        if (colliding !== exp_hit) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("colliding mismatch: expected %0b actual %0b", exp_hit, colliding);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic longint rand_coord(input longint span);
    longint v;
    v = longint'($urandom_range(0, 32'(2*span))) - span;
    if (v > (longint'(1) << (CB-1)) - 1) v = (longint'(1) << (CB-1)) - 1;
    if (v < -(longint'(1) << (CB-1))) v = -(longint'(1) << (CB-1));
    return v;
  endfunction

  function automatic logic [WB-1:0] rand_pos(input longint cx, cy, cz, span);
    return pack_pos(cx + rand_coord(span), cy + rand_coord(span), cz + rand_coord(span));
  endfunction

  function automatic logic [WB-1:0] rand_word();
    return WB'({$urandom(), $urandom()});
  endfunction

  task automatic test_directed();
    query_t q;
    longint mx, mn;
    mx = (longint'(1) << (CB-1)) - 1;
    mn = -(longint'(1) << (CB-1));
    // all zero: zero axes everywhere, colliding
    for (int i = 0; i < 6; i++) q.pos[i] = '0;
    q.ball = '0; q.tube = '0;
    send_word(q);
    // all ones in every field
    for (int i = 0; i < 6; i++) q.pos[i] = '1;
    q.ball = '1; q.tube = '1;
    send_word(q);
    // extremes of the coordinate range, largest radii
    q.pos[0] = pack_pos(mn, mn, mn); q.pos[1] = pack_pos(mx, mx, mx);
    q.pos[2] = pack_pos(mx, mn, mx); q.pos[3] = pack_pos(mn, mx, mn);
    q.pos[4] = pack_pos(mx, mx, mn); q.pos[5] = pack_pos(mn, mn, mx);
    send_word(q);
    q.ball = '0; q.tube = '0;
    send_word(q);
    // static scene, capsule far away: zero relative motion
    q.pos[0] = pack_pos(0, 0, 0); q.pos[1] = pack_pos(0, 0, 0);
    q.pos[2] = pack_pos(5000, 0, 0); q.pos[3] = pack_pos(5000, 3000, 0);
    q.pos[4] = q.pos[2]; q.pos[5] = q.pos[3];
    q.ball = 20'd256; q.tube = 20'd128;
    send_word(q);
    q.ball = 20'd4000;
    send_word(q);
    // degenerate capsule: zero-length axis segment
    q.pos[3] = q.pos[2]; q.pos[5] = q.pos[4];
    q.ball = 20'd10;
    send_word(q);
    // zero summed radius, endpoints on far side and touching the centre
    q.pos[0] = pack_pos(0, 0, 0); q.pos[1] = pack_pos(0, 100, 0);
    q.pos[2] = pack_pos(1, 0, 0); q.pos[3] = pack_pos(1, 0, 50);
    q.pos[4] = pack_pos(1, 100, 0); q.pos[5] = pack_pos(1, 100, 50);
    q.ball = '0; q.tube = '0;
    send_word(q);
    q.pos[2] = pack_pos(0, 0, 0);
    send_word(q);
    // sphere and capsule moving together
    q.pos[0] = pack_pos(-300, 0, 0); q.pos[1] = pack_pos(300, 0, 0);
    q.pos[2] = pack_pos(-300, 50, -20); q.pos[3] = pack_pos(-300, 50, 20);
    q.pos[4] = pack_pos(300, 50, -20); q.pos[5] = pack_pos(300, 50, 20);
    q.ball = 20'd20; q.tube = 20'd20;
    send_word(q);
    q.ball = 20'd40;
    send_word(q);
    // single bits walking through every field
    for (int b = 0; b < WB; b += 7) begin
      for (int i = 0; i < 6; i++) q.pos[i] = rand_word();
      q.pos[b % 6] = '0;
      q.pos[b % 6][b] = 1'b1;
      q.ball = RB'(1) << (b % RB);
      q.tube = RB'(1) << ((b + 9) % RB);
      send_word(q);
    end
  endtask

  // near-miss scenes: sphere sweep beside a capsule at a random offset
  task automatic test_random_scenes(input int count, input longint spread);
    query_t q;
    longint ox, oy, oz;
    for (int n = 0; n < count; n++) begin
      ox = rand_coord(spread); oy = rand_coord(spread); oz = rand_coord(spread);
      q.pos[0] = rand_pos(0, 0, 0, spread / 4);
      q.pos[1] = rand_pos(0, 0, 0, spread / 4);
      q.pos[2] = rand_pos(ox, oy, oz, spread / 4);
      q.pos[3] = rand_pos(ox, oy, oz, spread / 4);
      q.pos[4] = ($urandom_range(0, 5) == 0) ? q.pos[2] : rand_pos(ox, oy, oz, spread / 4);
      q.pos[5] = ($urandom_range(0, 5) == 0) ? q.pos[4] : rand_pos(ox, oy, oz, spread / 4);
      q.ball = RB'($urandom_range(0, 32'(spread / 3)));
      q.tube = RB'($urandom_range(0, 32'(spread / 3)));
      send_word(q);
    end
  endtask

  task automatic test_random_noise(input int count);
    query_t q;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 6; i++) q.pos[i] = rand_word();
      q.ball = RB'($urandom());
      q.tube = RB'($urandom());
      send_word(q);
    end
  endtask

  task automatic test_drain_pause();
    test_random_scenes(20, 2000);
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    test_random_scenes(20, 2000);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_scenes(250, 600);
    test_drain_pause();
    idle_on = 1'b0;
    test_random_scenes(120, 60000);
    idle_on = 1'b1;
    test_random_scenes(200, 500000);
    test_random_noise(200);
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (ssco_pkg::NUM_STAGES + 10) @(posedge clk);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ swept_sphere_capsule_overlap_test_core.f @@
hw/rtl/ssco_pkg.sv
hw/rtl/ssco_mul.sv
hw/rtl/swept_sphere_capsule_overlap_test_core.sv
tb/sv/tb_top.sv
